// ===== design/ipf_pkg.sv =====
// Shared constants, types and helpers for the integer printf formatter.
package ipf_pkg;

  localparam int DIGIT_SLOTS = 22;
  localparam int MAX_FIELD   = 60;

  localparam int DIG_IDX_W = $clog2(DIGIT_SLOTS);
  localparam int DIG_CNT_W = $clog2(DIGIT_SLOTS + 1);
  localparam int DIG_BITS  = 4 * DIGIT_SLOTS;
  localparam int OCT_BITS  = 3 * DIGIT_SLOTS;

  localparam int VAL_W      = 64;
  localparam int FIELD_W    = 6;
  localparam int LINE_W     = 7;
  localparam int LINE_MAX   = 63;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;
  localparam int FLAGS_W    = 5;

  localparam logic [1:0] RADIX_DEC  = 2'd0;
  localparam logic [1:0] RADIX_HEXL = 2'd1;
  localparam logic [1:0] RADIX_HEXU = 2'd2;
  localparam logic [1:0] RADIX_OCT  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIX     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_EN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PREC      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PREC_EN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAGS     = 3'd5;

  localparam int FLAG_LEFT  = 0;
  localparam int FLAG_ZERO  = 1;
  localparam int FLAG_PLUS  = 2;
  localparam int FLAG_SPACE = 3;
  localparam int FLAG_ALT   = 4;

  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_PLUS  = 7'h2B;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_LX    = 7'h78;
  localparam logic [6:0] CH_UX    = 7'h58;
  localparam logic [6:0] CH_UA10  = 7'h37;  // 'A' - 10
  localparam logic [6:0] CH_LA10  = 7'h57;  // 'a' - 10

  typedef struct packed {
    logic                 done;
    logic                 zero;
    logic [DIG_CNT_W-1:0] count;
  } dig_stat_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
    logic [6:0] base;
    if (d < 4'd10) begin
      base = CH_ZERO;
    end else if (upper) begin
      base = CH_UA10;
    end else begin
      base = CH_LA10;
    end
    return base + {3'b000, d};
  endfunction

endpackage

// ===== design/ipf_digits.sv =====
// Digit converter: binary to BCD by shift-and-add-3, or direct hex/octal split, then a top-digit scan.
module ipf_digits
  import ipf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic [VAL_W-1:0]    mag,
  input  logic [1:0]          radix,
  output logic [DIG_BITS-1:0] digits,
  output dig_stat_t           stat
);

  typedef enum logic [1:0] {S_IDLE, S_DABBLE, S_SCAN} state_t;

  state_t                     state_r;
  logic [VAL_W-1:0]           bin_r;
  logic [DIG_BITS-1:0]        dig_r;
  logic [$clog2(VAL_W)-1:0]   cnt_r;
  logic [DIG_IDX_W-1:0]       idx_r;
  dig_stat_t                  stat_r;

  logic [DIG_BITS-1:0]        adj;
  logic [DIG_BITS-1:0]        hex_load;
  logic [DIG_BITS-1:0]        oct_load;
  logic [OCT_BITS-1:0]        oct_ext;
  logic [3:0]                 cur_digit;

  always_comb begin
    hex_load = {{(DIG_BITS - VAL_W){1'b0}}, mag};
    oct_ext  = {{(OCT_BITS - VAL_W){1'b0}}, mag};
    for (int k = 0; k < DIGIT_SLOTS; k++) begin
      oct_load[4*k +: 4] = {1'b0, oct_ext[3*k +: 3]};
      adj[4*k +: 4] = (dig_r[4*k +: 4] >= 4'd5) ? dig_r[4*k +: 4] + 4'd3 : dig_r[4*k +: 4];
    end
  end

  assign cur_digit = dig_r[{idx_r, 2'b00} +: 4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stat_r.done <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          stat_r.done <= 1'b0;
          if (load) begin
            if (radix == RADIX_DEC) begin
              bin_r   <= mag;
              dig_r   <= '0;
              cnt_r   <= '0;
              state_r <= S_DABBLE;
            end else begin
              dig_r   <= (radix == RADIX_OCT) ? oct_load : hex_load;
              idx_r   <= DIG_IDX_W'(DIGIT_SLOTS - 1);
              state_r <= S_SCAN;
            end
          end
        end
        S_DABBLE: begin
          // correct each BCD digit, then shift in the next binary bit
          dig_r <= {adj[DIG_BITS-2:0], bin_r[VAL_W-1]};
          bin_r <= {bin_r[VAL_W-2:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == $clog2(VAL_W)'(VAL_W - 1)) begin
            idx_r   <= DIG_IDX_W'(DIGIT_SLOTS - 1);
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // walk down from the top slot to the first non-zero digit
          if (cur_digit != 4'd0 || idx_r == '0) begin
            stat_r.done  <= 1'b1;
            stat_r.zero  <= (cur_digit == 4'd0);
            stat_r.count <= DIG_CNT_W'(idx_r) + 1'b1;
            state_r      <= S_IDLE;
          end else begin
            idx_r <= idx_r - 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign digits = dig_r;
  assign stat   = stat_r;

endmodule

// ===== design/integer_printf_formatter.sv =====
// Top level of the printf-style integer formatter (d, x, X, o conversions).
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------------------
//  input   | in_value_bits, in_is_signed, in_is_wide | beat when start && !busy
//  config  | cfg_index, cfg_data                     | beat when cfg_valid && cfg_ready
//  result  | out_char_code, out_last                 | beat on out_strobe, one cycle
//
// Decimal items pass through the shift-and-add-3 converter; hex and octal digits load
// directly. A scan down the 22 digit slots finds the top digit, the digit count is
// handed over, S_CALC1, S_CALC2 and S_CALC3 lay out the field, then one character leaves
// per cycle (up to 63). busy stays high from the accepted beat until the last character
// is issued or an item that prints nothing is dropped. Reset is synchronous; it clears
// the config registers to zero and the sequencers to idle. Results are never stalled.
module integer_printf_formatter
  import ipf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [VAL_W-1:0]      in_value_bits,
  input  logic                  in_is_signed,
  input  logic                  in_is_wide,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_strobe,
  output logic [6:0]            out_char_code,
  output logic                  out_last
);

  typedef enum logic [2:0] {S_IDLE, S_CONV, S_CALC1, S_CALC2, S_CALC3, S_EMIT} state_t;

  // configuration registers
  logic [1:0]         radix_r;
  logic [FIELD_W-1:0] fwidth_r;
  logic               wen_r;
  logic [FIELD_W-1:0] prec_r;
  logic               pen_r;
  logic [FLAGS_W-1:0] flags_r;

  state_t               state_r;
  logic                 sgn_r;
  logic [6:0]           sign_ch_r;
  logic [DIG_CNT_W-1:0] n_r;
  logic [LINE_W-1:0]    lz_r;
  logic [1:0]           plen_r;
  logic [LINE_W-1:0]    lead_r;
  logic [LINE_W-1:0]    trail_r;
  logic [LINE_W-1:0]    b1_r, b2_r, b3_r, b4_r, b5_r;
  logic [LINE_W-1:0]    total_r;
  logic [LINE_W-1:0]    p_r;
  logic                 out_strobe_r;
  logic [6:0]           out_char_r;
  logic                 out_last_r;

  logic                 accept;
  logic [VAL_W-1:0]     v_sx;
  logic                 neg;
  logic [VAL_W-1:0]     mag;
  logic                 sgn_c;
  logic [6:0]           sign_ch_c;

  logic [DIG_BITS-1:0]  digits;
  dig_stat_t            dstat;

  logic [FIELD_W-1:0]   width_c;
  logic [FIELD_W-1:0]   prec_c;
  logic                 is_hex;
  logic [DIG_CNT_W-1:0] n_c;
  logic [LINE_W-1:0]    lz0_c;
  logic [LINE_W-1:0]    size_c;
  logic [LINE_W-1:0]    fill_c;
  logic                 zf_c;
  logic [LINE_W-1:0]    b1_c, b2_c, b3_c, b4_c, b5_c, sum_c;
  logic [LINE_W-1:0]    didx;
  logic [3:0]           dsel;
  logic [6:0]           ch_c;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r  <= '0;
      fwidth_r <= '0;
      wen_r    <= 1'b0;
      prec_r   <= '0;
      pen_r    <= 1'b0;
      flags_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RADIX:    radix_r  <= cfg_data[1:0];
        CFG_WIDTH:    fwidth_r <= cfg_data;
        CFG_WIDTH_EN: wen_r    <= cfg_data[0];
        CFG_PREC:     prec_r   <= cfg_data;
        CFG_PREC_EN:  pen_r    <= cfg_data[0];
        CFG_FLAGS:    flags_r  <= cfg_data[FLAGS_W-1:0];
        default:      ;
      endcase
    end
  end

  // sign handling and magnitude for the converter
  always_comb begin
    v_sx = in_value_bits;
    if (in_is_signed && !in_is_wide) begin
      v_sx = {{(VAL_W-32){in_value_bits[31]}}, in_value_bits[31:0]};
    end
    neg = in_is_signed && v_sx[VAL_W-1];
    if (!in_is_signed) begin
      mag = in_value_bits;
    end else if (radix_r == RADIX_DEC) begin
      mag = neg ? (~v_sx + 1'b1) : v_sx;
    end else begin
      mag = in_is_wide ? v_sx : {{(VAL_W-32){1'b0}}, v_sx[31:0]};
    end
    sgn_c     = in_is_signed && (neg || flags_r[FLAG_PLUS] || flags_r[FLAG_SPACE]);
    sign_ch_c = neg ? CH_MINUS : (flags_r[FLAG_PLUS] ? CH_PLUS : CH_SPACE);
  end

  ipf_digits u_digits (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (accept),
    .mag    (mag),
    .radix  (radix_r),
    .digits (digits),
    .stat   (dstat)
  );

  // field layout
  always_comb begin
    width_c = (fwidth_r > FIELD_W'(MAX_FIELD)) ? FIELD_W'(MAX_FIELD) : fwidth_r;
    prec_c  = (prec_r > FIELD_W'(MAX_FIELD)) ? FIELD_W'(MAX_FIELD) : prec_r;
    is_hex  = (radix_r == RADIX_HEXL) || (radix_r == RADIX_HEXU);

    n_c = (pen_r && dstat.zero && prec_c == '0) ? '0 : dstat.count;
    lz0_c = (pen_r && LINE_W'(prec_c) > LINE_W'(n_c)) ?
            LINE_W'(prec_c) - LINE_W'(n_c) : '0;

    size_c = LINE_W'(sgn_r) + LINE_W'(plen_r) + lz_r + LINE_W'(n_r);
    fill_c = (wen_r && LINE_W'(width_c) > size_c) ? LINE_W'(width_c) - size_c : '0;
    zf_c   = (fill_c != '0) && !flags_r[FLAG_LEFT] && flags_r[FLAG_ZERO] && !pen_r;

    b1_c  = lead_r;
    b2_c  = b1_c + LINE_W'(sgn_r);
    b3_c  = b2_c + LINE_W'(plen_r);
    b4_c  = b3_c + lz_r;
    b5_c  = b4_c + LINE_W'(n_r);
    sum_c = b5_c + trail_r;
  end

  // character at the current position
  always_comb begin
    didx = b5_r - LINE_W'(1) - p_r;
    dsel = digits[{didx[DIG_IDX_W-1:0], 2'b00} +: 4];
    if (p_r < b1_r) begin
      ch_c = CH_SPACE;
    end else if (p_r < b2_r) begin
      ch_c = sign_ch_r;
    end else if (p_r < b3_r) begin
      ch_c = (p_r == b2_r) ? CH_ZERO : ((radix_r == RADIX_HEXU) ? CH_UX : CH_LX);
    end else if (p_r < b4_r) begin
      ch_c = CH_ZERO;
    end else if (p_r < b5_r) begin
      ch_c = digit_char(dsel, radix_r == RADIX_HEXU);
    end else begin
      ch_c = CH_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            sgn_r     <= sgn_c;
            sign_ch_r <= sign_ch_c;
            state_r   <= S_CONV;
          end
        end
        S_CONV: begin
          if (dstat.done) begin
            state_r <= S_CALC1;
          end
        end
        S_CALC1: begin
          n_r    <= n_c;
          plen_r <= (flags_r[FLAG_ALT] && is_hex && !dstat.zero) ? 2'd2 : 2'd0;
          // alternate octal: force one leading zero unless precision zeros or the digits already supply one
          if (flags_r[FLAG_ALT] && radix_r == RADIX_OCT && lz0_c == '0 &&
              (n_c == '0 || !dstat.zero)) begin
            lz_r <= LINE_W'(1);
          end else begin
            lz_r <= lz0_c;
          end
          state_r <= S_CALC2;
        end
        S_CALC2: begin
          lead_r  <= (!flags_r[FLAG_LEFT] && !zf_c) ? fill_c : '0;
          lz_r    <= lz_r + (zf_c ? fill_c : '0);
          trail_r <= flags_r[FLAG_LEFT] ? fill_c : '0;
          state_r <= S_CALC3;
        end
        S_CALC3: begin
          b1_r    <= b1_c;
          b2_r    <= b2_c;
          b3_r    <= b3_c;
          b4_r    <= b4_c;
          b5_r    <= b5_c;
          total_r <= (sum_c > LINE_W'(LINE_MAX)) ? LINE_W'(LINE_MAX) : sum_c;
          p_r     <= '0;
          // drop items that print nothing
          state_r <= (sum_c == '0) ? S_IDLE : S_EMIT;
        end
        S_EMIT: begin
          out_strobe_r <= 1'b1;
          out_char_r   <= ch_c;
          out_last_r   <= (p_r == total_r - LINE_W'(1));
          p_r          <= p_r + 1'b1;
          if (p_r == total_r - LINE_W'(1)) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

endmodule

// ===== tb/printf_char_checker.sv =====
// Checker for the printf integer formatter: predicts each item's characters and compares them.
module printf_char_checker
  import ipf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [VAL_W-1:0]      in_value_bits,
  input  logic                  in_is_signed,
  input  logic                  in_is_wide,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_strobe,
  input  logic [6:0]            out_char_code,
  input  logic                  out_last,
  output int                    mismatch_count,
  output int                    chars_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } char_beat_t;

  localparam logic [0:15][7:0] LOWER_GLYPHS = "0123456789abcdef";
  localparam logic [0:15][7:0] UPPER_GLYPHS = "0123456789ABCDEF";

  logic [1:0] radix_q;
  logic [5:0] width_q;
  logic       width_en_q;
  logic [5:0] prec_q;
  logic       prec_en_q;
  logic [4:0] flags_q;

  char_beat_t expected_chars[$];
  char_beat_t oldest;
  int         errors = 0;

  assign mismatch_count = errors;

  // Queue up the characters one integer should produce under the current format.
  function automatic void format_integer(input logic [63:0] raw, input logic sgn,
                                         input logic wide);
    logic [63:0] v;
    logic [63:0] mag;
    logic [63:0] base;
    logic        neg;
    logic        is_zero;
    logic        has_sign;
    logic        zero_pad;
    logic        left;
    logic [6:0]  sign_ch;
    logic [3:0]  d;
    logic [6:0]  rev[DIGIT_SLOTS];
    logic [6:0]  text[$];
    int          n;
    int          lz;
    int          plen;
    int          fill;
    int          total;
    int          prec;
    int          fwidth;
    int          i;
    char_beat_t  beat;
    left     = flags_q[FLAG_LEFT];
    prec     = (prec_q > MAX_FIELD) ? MAX_FIELD : int'(prec_q);
    fwidth   = (width_q > MAX_FIELD) ? MAX_FIELD : int'(width_q);
    base     = (radix_q == RADIX_DEC) ? 64'd10 : ((radix_q == RADIX_OCT) ? 64'd8 : 64'd16);
    v        = raw;
    mag      = raw;
    neg      = 1'b0;
    has_sign = 1'b0;
    sign_ch  = CH_SPACE;
    if (sgn) begin
      if (!wide) begin
        v = {{32{raw[31]}}, raw[31:0]};
      end
      neg = v[63];
      // hex and octal show the two's complement bits, decimal the magnitude
      if (radix_q == RADIX_DEC) begin
        mag = neg ? -v : v;
      end else begin
        mag = wide ? v : {32'd0, v[31:0]};
      end
      has_sign = neg || flags_q[FLAG_PLUS] || flags_q[FLAG_SPACE];
      sign_ch  = neg ? CH_MINUS : (flags_q[FLAG_PLUS] ? CH_PLUS : CH_SPACE);
    end
    is_zero = (v == 64'd0);

    n = 0;
    do begin
      d = 4'(mag % base);
      rev[n] = (radix_q == RADIX_HEXU) ? UPPER_GLYPHS[d][6:0] : LOWER_GLYPHS[d][6:0];
      mag = mag / base;
      n++;
    end while (mag != 0 && n < DIGIT_SLOTS);

    if (prec_en_q && is_zero && prec == 0) begin
      n = 0;
    end
    lz   = (prec_en_q && prec > n) ? prec - n : 0;
    plen = 0;
    if (flags_q[FLAG_ALT]) begin
      if ((radix_q == RADIX_HEXL || radix_q == RADIX_HEXU) && !is_zero) begin
        plen = 2;
      end else if (radix_q == RADIX_OCT && lz == 0 && (n == 0 || rev[n-1] != CH_ZERO)) begin
        lz = 1;
      end
    end

    total    = int'(has_sign) + plen + lz + n;
    fill     = (width_en_q && fwidth > total) ? fwidth - total : 0;
    zero_pad = (fill > 0) && !left && flags_q[FLAG_ZERO] && !prec_en_q;

    if (fill > 0 && !left && !zero_pad) begin
      repeat (fill) text.push_back(CH_SPACE);
    end
    if (has_sign) begin
      text.push_back(sign_ch);
    end
    if (plen != 0) begin
      text.push_back(CH_ZERO);
      text.push_back((radix_q == RADIX_HEXU) ? CH_UX : CH_LX);
    end
    if (zero_pad) begin
      lz += fill;
    end
    repeat (lz) text.push_back(CH_ZERO);
    for (i = n; i > 0; i--) begin
      text.push_back(rev[i-1]);
    end
    if (fill > 0 && left) begin
      repeat (fill) text.push_back(CH_SPACE);
    end

    for (i = 0; i < text.size() && i < LINE_MAX; i++) begin
      beat.code = text[i];
      beat.last = (i + 1 == text.size()) || (i + 1 == LINE_MAX);
      expected_chars.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      radix_q    = RADIX_DEC;
      width_q    = '0;
      width_en_q = 1'b0;
      prec_q     = '0;
      prec_en_q  = 1'b0;
      flags_q    = '0;
      expected_chars.delete();
    end else begin
      if (out_strobe) begin
        if (expected_chars.size() == 0) begin
          errors++;
          $error("char_code %h (last %b) arrived with no character expected",
                 out_char_code, out_last);
        end else begin
          oldest = expected_chars.pop_front();
          if (out_char_code !== oldest.code) begin
            errors++;
            $error("char_code mismatch: expected %h, got %h", oldest.code, out_char_code);
          end
          if (out_last !== oldest.last) begin
            errors++;
            $error("last mismatch: expected %b, got %b", oldest.last, out_last);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RADIX:    radix_q    = cfg_data[1:0];
          CFG_WIDTH:    width_q    = cfg_data[5:0];
          CFG_WIDTH_EN: width_en_q = cfg_data[0];
          CFG_PREC:     prec_q     = cfg_data[5:0];
          CFG_PREC_EN:  prec_en_q  = cfg_data[0];
          CFG_FLAGS:    flags_q    = cfg_data[FLAGS_W-1:0];
          default:      ;  // drop writes to unused indexes
        endcase
      end
      if (start && !busy) begin
        format_integer(in_value_bits, in_is_signed, in_is_wide);
      end
    end
    chars_pending <= expected_chars.size();
  end

endmodule

// ===== tb/tb_integer_printf_formatter.sv =====
// Testbench top for the printf integer formatter: drives formats and integers, gives the verdict.
module tb_integer_printf_formatter;
  import ipf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY_CYCLES = 160;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam logic [4:0] FL_LEFT  = 5'(1 << FLAG_LEFT);
  localparam logic [4:0] FL_ZERO  = 5'(1 << FLAG_ZERO);
  localparam logic [4:0] FL_PLUS  = 5'(1 << FLAG_PLUS);
  localparam logic [4:0] FL_SPACE = 5'(1 << FLAG_SPACE);
  localparam logic [4:0] FL_ALT   = 5'(1 << FLAG_ALT);

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [VAL_W-1:0]      in_value_bits = '0;
  logic                  in_is_signed = 1'b0;
  logic                  in_is_wide = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  out_strobe;
  logic [6:0]            out_char_code;
  logic                  out_last;

  int mismatches;
  int pending;
  bit calm = 1'b0;

  integer_printf_formatter DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value_bits(in_value_bits),
    .in_is_signed (in_is_signed),
    .in_is_wide   (in_is_wide),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_strobe   (out_strobe),
    .out_char_code(out_char_code),
    .out_last     (out_last)
  );

  printf_char_checker u_char_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value_bits (in_value_bits),
    .in_is_signed  (in_is_signed),
    .in_is_wide    (in_is_wide),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_strobe    (out_strobe),
    .out_char_code (out_char_code),
    .out_last      (out_last),
    .mismatch_count(mismatches),
    .chars_pending (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Leave cfg_valid high on return so back-to-back writes never toggle it within a step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    while (!calm && $urandom_range(99) < 32) begin
      cfg_valid <= 1'b0;
      @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Hold until every character has come out and any silent item has drained.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (LATENCY_CYCLES) @(posedge clk);
  endtask

  task automatic apply_format(input logic [1:0] radix, input logic [5:0] fwidth,
                              input logic wen, input logic [5:0] prec, input logic pen,
                              input logic [4:0] flags);
    logic [3:0] junk4;
    logic [4:0] junk5;
    logic       junk1;
    settle();
    junk4 = 4'($urandom);
    junk5 = 5'($urandom);
    junk1 = 1'($urandom);
    write_reg(CFG_RADIX, {junk4, radix});
    write_reg(CFG_WIDTH, fwidth);
    write_reg(CFG_WIDTH_EN, {junk5, wen});
    junk5 = 5'($urandom);
    write_reg(CFG_PREC, prec);
    write_reg(CFG_PREC_EN, {junk5, pen});
    write_reg(CFG_FLAGS, {junk1, flags});
    if ($urandom_range(3) == 0) begin
      write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, CFG_DATA_W'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input logic [63:0] value, input logic sgn, input logic wide);
    while (!calm && $urandom_range(99) < 32) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_value_bits <= value;
    in_is_signed  <= sgn;
    in_is_wide    <= wide;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [63:0] pick_value();
    logic [63:0] r;
    logic [63:0] tiny;
    r    = {$urandom, $urandom};
    tiny = 64'($urandom_range(20));
    pick_value = r;
    case ($urandom_range(7))
      0: pick_value = tiny;
      1: pick_value = -tiny;
      // narrow negatives with junk above bit 31
      2: pick_value = {r[63:32], 32'd0 - tiny[31:0]};
      3: pick_value = 64'd1 << r[5:0];
      4: begin
        case (tiny[1:0])
          2'd0: pick_value[31:0] = 32'h7FFF_FFFF;
          2'd1: pick_value[31:0] = 32'h8000_0000;
          2'd2: pick_value[31:0] = 32'hFFFF_FFFF;
          default: pick_value[31:0] = 32'h0000_0000;
        endcase
      end
      5: begin
        case (tiny[1:0])
          2'd0: pick_value = 64'h0;
          2'd1: pick_value = 64'hFFFF_FFFF_FFFF_FFFF;
          2'd2: pick_value = 64'h8000_0000_0000_0000;
          default: pick_value = 64'h7FFF_FFFF_FFFF_FFFF;
        endcase
      end
      default: pick_value = r;
    endcase
  endfunction

  task automatic random_format();
    logic [5:0] fwidth;
    logic [5:0] prec;
    fwidth = 6'(($urandom_range(5) == 0) ? $urandom_range(63, 55) : $urandom_range(24));
    prec   = 6'(($urandom_range(5) == 0) ? $urandom_range(63, 55) : $urandom_range(24));
    apply_format(2'($urandom_range(3)), fwidth, 1'($urandom_range(1)), prec,
                 1'($urandom_range(1)), 5'($urandom_range(31)));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // decimal, plain: extremes of both widths
    apply_format(RADIX_DEC, 6'd0, 1'b0, 6'd0, 1'b0, 5'd0);
    send_item(64'h0, 1'b0, 1'b0);
    send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
    send_item(64'hDEAD_BEEF_8000_0000, 1'b1, 1'b0);
    send_item(64'h8000_0000_0000_0000, 1'b1, 1'b1);
    send_item(64'hFFFF_FFFF_0000_0000, 1'b1, 1'b0);
    send_item(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);

    // zero precision: unsigned zero prints nothing, signed zero only the sign
    apply_format(RADIX_DEC, 6'd0, 1'b0, 6'd0, 1'b1, FL_PLUS);
    send_item(64'h0, 1'b0, 1'b1);
    send_item(64'h0, 1'b1, 1'b1);
    send_item(64'h5, 1'b1, 1'b0);

    apply_format(RADIX_HEXL, 6'd20, 1'b1, 6'd0, 1'b0, FL_ALT | FL_ZERO);
    send_item(64'hFFFF_FFFF, 1'b1, 1'b0);
    send_item(64'h0, 1'b0, 1'b0);
    send_item(64'hAB_CDEF, 1'b0, 1'b0);

    // left beats zero fill, plus beats space, width saturates
    apply_format(RADIX_HEXU, 6'd63, 1'b1, 6'd0, 1'b0,
                 FL_ALT | FL_ZERO | FL_LEFT | FL_PLUS | FL_SPACE);
    send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
    send_item(64'h0123_4567_89AB_CDEF, 1'b0, 1'b1);
    send_item(64'h1, 1'b1, 1'b1);

    apply_format(RADIX_OCT, 6'd0, 1'b0, 6'd0, 1'b1, FL_ALT);
    send_item(64'h0, 1'b0, 1'b0);
    send_item(64'h8, 1'b0, 1'b0);
    send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
    send_item(64'hFFFF_FFFF, 1'b1, 1'b0);

    apply_format(RADIX_OCT, 6'd63, 1'b1, 6'd63, 1'b1, FL_SPACE | FL_ZERO);
    send_item(64'h7, 1'b1, 1'b0);
    send_item(64'h0, 1'b0, 1'b0);

    // longest line: sign, prefix and saturated precision
    apply_format(RADIX_HEXL, 6'd0, 1'b0, 6'd63, 1'b1, FL_ALT | FL_PLUS);
    send_item(64'h1, 1'b1, 1'b1);

    // zero fill ignored under a precision
    apply_format(RADIX_DEC, 6'd10, 1'b1, 6'd4, 1'b1, FL_ZERO | FL_SPACE);
    send_item(64'h2A, 1'b1, 1'b0);
    send_item(64'hFFFF_FFFF_FFFF_FFD6, 1'b1, 1'b1);

    for (int phase = 0; phase < 12; phase++) begin
      random_format();
      calm = (phase == 4);
      repeat (25) send_item(pick_value(), 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
    calm = 1'b0;

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/ipf_pkg.sv
design/ipf_digits.sv
design/integer_printf_formatter.sv
tb/printf_char_checker.sv
tb/tb_integer_printf_formatter.sv
